// ----- design/centered_moving_average_edge_hold_defines.svh -----
// assertion macros shared by the centered moving average design files
// no dependencies; taken in by `include where a module asserts
`ifndef CENTERED_MOVING_AVERAGE_EDGE_HOLD_DEFINES_SVH
`define CENTERED_MOVING_AVERAGE_EDGE_HOLD_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CMAH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define CMAH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cmah_pkg.sv -----
// shared types, widths, state codes and reciprocal table for the moving average
// no dependencies; imported by the top level, cmah_div and the testbench
package cmah_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int MEAN_W          = 24;
  localparam int SUM_W           = 22;
  localparam int FRAC_W          = 8;
  localparam int NUM_W           = SUM_W + FRAC_W;
  localparam int RECIP_W         = 32;
  localparam int DIV_W           = 6;
  localparam int CFG_W           = 6;
  localparam int CMAH_MAX_WINDOW = 63;

  // input beat
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } cmah_in_t;

  // output beat
  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic                     last_result;
    logic                     short_record;
  } cmah_out_t;

  // request into the divide pipeline
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
    logic [DIV_W-1:0]        divisor;
  } cmah_div_req_t;

  // answer from the divide pipeline
  typedef struct packed {
    logic                     done;
    logic signed [MEAN_W-1:0] mean;
  } cmah_div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } cmah_state_t;

  // floor((2^32 - 1) / d); the estimate it gives is at most one below the quotient
  function automatic logic [RECIP_W-1:0] cmah_recip(input logic [DIV_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      6'd1:    r = 32'd4294967295;
      6'd2:    r = 32'd2147483647;
      6'd3:    r = 32'd1431655765;
      6'd4:    r = 32'd1073741823;
      6'd5:    r = 32'd858993459;
      6'd6:    r = 32'd715827882;
      6'd7:    r = 32'd613566756;
      6'd8:    r = 32'd536870911;
      6'd9:    r = 32'd477218588;
      6'd10:   r = 32'd429496729;
      6'd11:   r = 32'd390451572;
      6'd12:   r = 32'd357913941;
      6'd13:   r = 32'd330382099;
      6'd14:   r = 32'd306783378;
      6'd15:   r = 32'd286331153;
      6'd16:   r = 32'd268435455;
      6'd17:   r = 32'd252645135;
      6'd18:   r = 32'd238609294;
      6'd19:   r = 32'd226050910;
      6'd20:   r = 32'd214748364;
      6'd21:   r = 32'd204522252;
      6'd22:   r = 32'd195225786;
      6'd23:   r = 32'd186737708;
      6'd24:   r = 32'd178956970;
      6'd25:   r = 32'd171798691;
      6'd26:   r = 32'd165191049;
      6'd27:   r = 32'd159072862;
      6'd28:   r = 32'd153391689;
      6'd29:   r = 32'd148102320;
      6'd30:   r = 32'd143165576;
      6'd31:   r = 32'd138547332;
      6'd32:   r = 32'd134217727;
      6'd33:   r = 32'd130150524;
      6'd34:   r = 32'd126322567;
      6'd35:   r = 32'd122713351;
      6'd36:   r = 32'd119304647;
      6'd37:   r = 32'd116080197;
      6'd38:   r = 32'd113025455;
      6'd39:   r = 32'd110127366;
      6'd40:   r = 32'd107374182;
      6'd41:   r = 32'd104755299;
      6'd42:   r = 32'd102261126;
      6'd43:   r = 32'd99882960;
      6'd44:   r = 32'd97612893;
      6'd45:   r = 32'd95443717;
      6'd46:   r = 32'd93368854;
      6'd47:   r = 32'd91382282;
      6'd48:   r = 32'd89478485;
      6'd49:   r = 32'd87652393;
      6'd50:   r = 32'd85899345;
      6'd51:   r = 32'd84215045;
      6'd52:   r = 32'd82595524;
      6'd53:   r = 32'd81037118;
      6'd54:   r = 32'd79536431;
      6'd55:   r = 32'd78090314;
      6'd56:   r = 32'd76695844;
      6'd57:   r = 32'd75350303;
      6'd58:   r = 32'd74051160;
      6'd59:   r = 32'd72796055;
      6'd60:   r = 32'd71582788;
      6'd61:   r = 32'd70409299;
      6'd62:   r = 32'd69273666;
      6'd63:   r = 32'd68174084;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/centered_moving_average_edge_hold.sv -----
// Centered moving average with edge hold. Takes one signed 16-bit sample per beat and emits
// means of an odd window (order rounded up to odd, at least one) with 8 fraction bits,
// rounded to nearest. The first full mean is repeated for the leading half window and the
// last mean for the trailing half window; a record shorter than the window returns one
// flagged copy of its running mean per sample. Samples live in a registered-read delay-line
// ram; no clearing pass is run, as only entries of the current record are read. A sample that
// gives no result is accepted with the delay-line read, then updates the sum. A sample that
// gives results goes through the sum update and the four-stage reciprocal divider to its
// first result, then one further copy per cycle while the output is taken. The next sample is
// accepted once the final copy is in the output register. Depends on cmah_pkg, cmah_ram,
// cmah_div and the defines header.
`include "centered_moving_average_edge_hold_defines.svh"

module centered_moving_average_edge_hold #(
  parameter int MAX_WINDOW = cmah_pkg::CMAH_MAX_WINDOW
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [cmah_pkg::CFG_W-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cmah_pkg::cmah_in_t       in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cmah_pkg::cmah_out_t      out_data
);

  import cmah_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW + 1);
  localparam int DEPTH  = 2 ** PTR_W;
  localparam int EXT_W  = SUM_W - SAMPLE_W;
  localparam int W_ODD  = (MAX_WINDOW / 2) * 2 + 1;
  localparam int W_CAP  = (W_ODD > MAX_WINDOW) ? MAX_WINDOW : W_ODD;

  cmah_state_t             state;
  cmah_state_t             state_next;
  logic [CFG_W-1:0]        window_order;
  logic signed [SUM_W-1:0] running_sum;
  logic [PTR_W-1:0]        seen;
  logic [PTR_W-1:0]        wr_ptr;
  logic [SAMPLE_W-1:0]     smp;
  logic                    smp_last;
  logic [PTR_W-1:0]        copies;
  logic                    plan_short;
  logic                    plan_last;
  logic signed [MEAN_W-1:0] mean_hold;

  logic                    in_fire;
  logic                    cfg_fire;
  logic                    out_load;
  logic                    ram_we;
  logic [PTR_W-1:0]        ram_raddr;
  logic [SAMPLE_W-1:0]     ram_rdata;
  logic [CFG_W-1:0]        w_raw;
  logic [PTR_W-1:0]        win_len;
  logic [PTR_W-1:0]        half;
  logic                    full;
  logic                    just;
  logic                    need_div;
  logic [PTR_W-1:0]        seen_new;
  logic [PTR_W-1:0]        copies_next;
  logic signed [SUM_W-1:0] rd_ext;
  logic signed [SUM_W-1:0] smp_ext;
  logic signed [SUM_W-1:0] new_sum;
  cmah_div_req_t           div_req;
  cmah_div_rsp_t           div_rsp;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  // window length from the order register, capped by the delay line
  always_comb begin
    w_raw   = {window_order[CFG_W-1:1], 1'b1};
    win_len = (w_raw > CFG_W'(W_CAP)) ? PTR_W'(W_CAP) : w_raw[PTR_W-1:0];
    half    = win_len >> 1;
  end

  // sum update and result plan for the sample in hand
  always_comb begin
    full     = (seen == win_len);
    just     = !full && (PTR_W'(seen + 1'b1) == win_len);
    seen_new = full ? seen : PTR_W'(seen + 1'b1);
    rd_ext   = {{EXT_W{ram_rdata[SAMPLE_W-1]}}, ram_rdata};
    smp_ext  = {{EXT_W{smp[SAMPLE_W-1]}}, smp};
    new_sum  = running_sum - (full ? rd_ext : '0) + smp_ext;
    need_div = full || just || smp_last;
    if (full || just) begin
      copies_next = PTR_W'((full ? PTR_W'(1) : PTR_W'(half + 1'b1)) + (smp_last ? half : '0));
    end else begin
      copies_next = seen_new;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = need_div ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && (copies == PTR_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready        = (state == ST_IDLE);
    ram_we          = in_fire;
    ram_raddr       = wr_ptr - win_len;
    div_req.valid   = (state == ST_SUM) && need_div;
    div_req.sum     = new_sum;
    div_req.divisor = (full || just) ? DIV_W'(win_len) : DIV_W'(seen_new);
    out_load        = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  // delay line
  cmah_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (in_data.sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // rounded mean
  cmah_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // control state and record state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_order <= CFG_W'(1);
      running_sum  <= '0;
      seen         <= '0;
      wr_ptr       <= '0;
      copies       <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        window_order <= cfg_data;
        running_sum  <= '0;
        seen         <= '0;
        wr_ptr       <= '0;
      end else if (state == ST_SUM) begin
        running_sum <= smp_last ? '0 : new_sum;
        seen        <= smp_last ? '0 : seen_new;
        wr_ptr      <= smp_last ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (state == ST_SUM) begin
        copies <= copies_next;
      end else if (out_load) begin
        copies <= copies - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sample latch, plan flags and output beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp      <= in_data.sample;
      smp_last <= in_data.last_sample;
    end
    if (state == ST_SUM) begin
      plan_short <= !(full || just);
      plan_last  <= smp_last;
    end
    if (div_rsp.done) begin
      mean_hold <= div_rsp.mean;
    end
    if (out_load) begin
      out_data.mean         <= mean_hold;
      out_data.last_result  <= plan_last && (copies == PTR_W'(1));
      out_data.short_record <= plan_short;
    end
  end

  `CMAH_ASSERT_IMP(a_seen_bound, clk, rst, 1'b1, seen <= win_len, "sample count beyond window")
  `CMAH_ASSERT_IMP(a_emit_count, clk, rst, state == ST_EMIT, copies != '0, "emitting with no copies left")
  `CMAH_ASSERT_IMP(a_record_closed, clk, rst, (state == ST_EMIT) && plan_last, (seen == '0) && (wr_ptr == '0), "record not closed after last sample")
  `CMAH_ASSERT_IMP(a_div_expected, clk, rst, div_rsp.done, state == ST_DIV, "divide result outside wait state")

endmodule

// ----- design/cmah_ram.sv -----
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module cmah_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/cmah_div.sv -----
// rounded divide of a window sum by a small count: sum*256/d, ties away from zero
// reciprocal multiply with one correction step; depends on cmah_pkg and the defines header
`include "centered_moving_average_edge_hold_defines.svh"

module cmah_div (
  input  logic                   clk,
  input  logic                   rst,
  input  cmah_pkg::cmah_div_req_t req,
  output cmah_pkg::cmah_div_rsp_t rsp
);

  import cmah_pkg::*;

  localparam int PROD_W = NUM_W + RECIP_W;
  localparam int QD_W   = NUM_W + DIV_W;

  logic                     s0_valid;
  logic                     s1_valid;
  logic                     s2_valid;
  logic [NUM_W-1:0]         s0_num;
  logic [NUM_W-1:0]         s1_num;
  logic [NUM_W-1:0]         s2_num;
  logic                     s0_neg;
  logic                     s1_neg;
  logic                     s2_neg;
  logic [DIV_W-1:0]         s0_div;
  logic [DIV_W-1:0]         s1_div;
  logic [DIV_W-1:0]         s2_div;
  logic [PROD_W-1:0]        s1_prod;
  logic [NUM_W-1:0]         s2_qest;
  logic [QD_W-1:0]          s2_qd;
  logic [SUM_W-1:0]         mag;
  logic [NUM_W-1:0]         num_next;
  logic [NUM_W-1:0]         q_est;
  logic [QD_W-1:0]          rem;
  logic [NUM_W-1:0]         q_fix;
  logic [NUM_W-1:0]         q_signed;
  logic                     done;
  logic signed [MEAN_W-1:0] mean;

  // magnitude scaled by 256, plus half the divisor for rounding
  always_comb begin
    mag      = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
    num_next = {mag, {FRAC_W{1'b0}}} + NUM_W'(req.divisor >> 1);
  end

  // quotient estimate from the reciprocal product
  assign q_est = s1_prod[PROD_W-1 -: NUM_W];

  // correction and sign restore
  always_comb begin
    rem      = {{DIV_W{1'b0}}, s2_num} - s2_qd;
    q_fix    = (rem >= QD_W'(s2_div)) ? s2_qest + 1'b1 : s2_qest;
    q_signed = s2_neg ? -q_fix : q_fix;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s0_valid <= req.valid;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    s0_num  <= num_next;
    s0_neg  <= req.sum[SUM_W-1];
    s0_div  <= req.divisor;
    s1_prod <= s0_num * cmah_recip(s0_div);
    s1_num  <= s0_num;
    s1_neg  <= s0_neg;
    s1_div  <= s0_div;
    s2_qest <= q_est;
    s2_qd   <= q_est * s1_div;
    s2_num  <= s1_num;
    s2_neg  <= s1_neg;
    s2_div  <= s1_div;
    mean    <= q_signed[MEAN_W-1:0];
  end

  assign rsp.done = done;
  assign rsp.mean = mean;

  `CMAH_ASSERT_IMP(a_div_no_overlap, clk, rst, req.valid, !(s0_valid || s1_valid || s2_valid), "divide request while busy")
  `CMAH_ASSERT_IMP(a_div_rem_bound, clk, rst, s2_valid, rem < {s2_div, 1'b0}, "estimate more than one below")
  `CMAH_ASSERT_NXT(a_div_done_single, clk, rst, rsp.done, !rsp.done, "done held longer than one cycle")

endmodule

// ----- tb/centered_moving_average_edge_hold_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the centered moving average with edge hold
// depends on cmah_pkg and the centered_moving_average_edge_hold top level
module centered_moving_average_edge_hold_tb;
  import cmah_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 180;

  // predicts every mean beat and checks what the block returns
  class mean_scoreboard;
    logic [CFG_W-1:0]           order;
    logic signed [SAMPLE_W-1:0] line [64];
    logic [5:0]                 wr_ptr;
    int                         running;
    int                         seen;
    logic signed [MEAN_W-1:0]   held;
    cmah_out_t                  pending_means [$];
    int                         mismatches;

    function new();
      order      = 6'd1;
      wr_ptr     = '0;
      running    = 0;
      seen       = 0;
      held       = '0;
      mismatches = 0;
      foreach (line[i]) line[i] = '0;
    endfunction

    // new order closes any open record
    function void set_order(logic [CFG_W-1:0] value);
      order   = value;
      running = 0;
      seen    = 0;
      wr_ptr  = '0;
    endfunction

    // sum * 256 / div, nearest, ties away from zero
    function logic signed [MEAN_W-1:0] rounded_mean(int total, int div);
      longint mag;
      longint q;
      mag = (total < 0) ? -longint'(total) : longint'(total);
      q = (mag * 256 + div / 2) / div;
      if (total < 0) q = -q;
      return q[MEAN_W-1:0];
    endfunction

    function void queue_mean(logic signed [MEAN_W-1:0] m, logic shrt);
      cmah_out_t r;
      r.mean         = m;
      r.last_result  = 1'b0;
      r.short_record = shrt;
      pending_means.push_back(r);
    endfunction

    function void take_sample(cmah_in_t item);
      int                       w;
      int                       h;
      int                       first_size;
      logic [5:0]               oldest;
      logic signed [MEAN_W-1:0] short_mean;
      w = (int'(order) / 2) * 2 + 1;
      h = w / 2;
      first_size = pending_means.size();
      oldest = wr_ptr - 6'(w);
      // slide the window
      if (seen == w) running -= int'(line[oldest]);
      running += int'(item.sample);
      line[wr_ptr] = item.sample;
      wr_ptr = wr_ptr + 6'd1;
      // steady state, or leading edge hold once the window fills
      if (seen == w) begin
        held = rounded_mean(running, w);
        queue_mean(held, 1'b0);
      end else if (seen + 1 == w) begin
        held = rounded_mean(running, w);
        repeat (h + 1) queue_mean(held, 1'b0);
      end
      if (seen < w) seen++;
      // record end: trailing hold or short record
      if (item.last_sample) begin
        if (seen < w) begin
          short_mean = rounded_mean(running, seen);
          repeat (seen) queue_mean(short_mean, 1'b1);
        end else begin
          repeat (h) queue_mean(held, 1'b0);
        end
        if (pending_means.size() > first_size)
          pending_means[pending_means.size() - 1].last_result = 1'b1;
        running = 0;
        seen    = 0;
        wr_ptr  = '0;
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void check_mean(cmah_out_t got);
      cmah_out_t want;
      if (pending_means.size() == 0) begin
        note_mismatch($sformatf("unexpected beat mean %0d last %0b short %0b",
                                got.mean, got.last_result, got.short_record));
        return;
      end
      want = pending_means.pop_front();
      if (got.mean !== want.mean || got.last_result !== want.last_result ||
          got.short_record !== want.short_record)
        note_mismatch($sformatf("expected mean %0d last %0b short %0b, got mean %0d last %0b short %0b",
                                want.mean, want.last_result, want.short_record,
                                got.mean, got.last_result, got.short_record));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  cmah_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  cmah_out_t          out_data;

  mean_scoreboard     sb;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 sent;

  centered_moving_average_edge_hold i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // observe accepted beats on all three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_mean(out_data);
      if (cfg_valid && cfg_ready) sb.set_order(cfg_data);
      if (in_valid && in_ready) sb.take_sample(in_data);
    end
  end

  // one input beat, after a random sender gap
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst);
    cmah_in_t item;
    // idling profile follows progress through the run
    if (sent < 85) begin
      send_idle_pct = 17;
      recv_idle_pct = 60;
    end else if (sent < 170) begin
      send_idle_pct = 60;
      recv_idle_pct = 17;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.sample      = s;
    item.last_sample = lst;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // hold the sender until every expected beat is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_order(input int value);
    drain();
    cfg_data  <= CFG_W'(value);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // a record of len samples; style picks random content or extremes
  task automatic send_record(input int len, input bit closed, input int style);
    logic signed [SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      case (style)
        0:       s = 16'sh7fff;
        1:       s = -16'sh8000;
        2:       s = i[0] ? -16'sh8000 : 16'sh7fff;
        default: s = SAMPLE_W'($urandom);
      endcase
      send_sample(s, closed && (i == len - 1));
    end
  endtask

  // run length guard
  initial begin
    #20_000_000;
    $display("centered_moving_average_edge_hold_tb: FAIL");
    $finish;
  end

  initial begin
    int  random_sent;
    int  order;
    int  w;
    int  nrec;
    int  len;
    bit  big_done;
    bit  paused_once;
    sb            = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 60;
    sent          = 0;
    random_sent   = 0;
    big_done      = 1'b0;
    paused_once   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset order gives a window of one: a record at the extremes
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    // records of one and two samples
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sh0001, 1'b1);
    // order zero means a window of one
    write_order(0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    // widest window: short record, then an open record dropped by a write
    write_order(63);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b1);
    send_sample(16'sh0005, 1'b0);
    send_sample(-16'sh0005, 1'b0);
    // even order rounds up to a window of seven
    write_order(6);
    send_record(8, 1'b1, 2);

    // random phases of records under changing orders
    while (random_sent < RANDOM_ITEMS) begin
      if (!big_done && random_sent >= 40) begin
        order    = 63;
        big_done = 1'b1;
      end else begin
        case ($urandom_range(19))
          0:       order = 62;
          1:       order = 0;
          2:       order = 1;
          3:       order = $urandom_range(63);
          default: order = $urandom_range(2, 14);
        endcase
      end
      write_order(order);
      w = (order / 2) * 2 + 1;
      nrec = (w >= 31) ? 1 : $urandom_range(1, 4);
      for (int r = 0; r < nrec; r++) begin
        if (w == 1) len = $urandom_range(1, 6);
        else if ($urandom_range(3) == 0) len = $urandom_range(1, w - 1);
        else len = $urandom_range(w, w + ((w >= 31) ? 3 : 6));
        // the final record of a phase is sometimes left open
        send_record(len, !(r == nrec - 1 && $urandom_range(4) == 0), $urandom_range(7));
        random_sent += len;
        // pause the sender once until the output side has caught up
        if (!paused_once && random_sent >= 100) begin
          drain();
          paused_once = 1'b1;
        end
      end
    end

    // let the last beats out
    in_valid <= 1'b0;
    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_means.size() == 0)
      $display("centered_moving_average_edge_hold_tb: PASS");
    else
      $display("centered_moving_average_edge_hold_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/cmah_pkg.sv
design/cmah_ram.sv
design/cmah_div.sv
design/centered_moving_average_edge_hold.sv
tb/centered_moving_average_edge_hold_tb.sv
